/* src/tmd_pkg.sv */
// shared types, constants and helpers of the typed message deframer
package tmd_pkg;

	// default largest frame in bytes, header included
	localparam int MAX_FRAME_DEF = 2048;

	// widths of the frame size sum
	localparam int TOTAL_W = 17;

	// type words on the wire
	localparam logic [15:0] TYPE_MOVE   = 16'd100;
	localparam logic [15:0] TYPE_RESIZE = 16'd101;
	localparam logic [15:0] TYPE_AMSG   = 16'd110;
	localparam logic [15:0] TYPE_SMSG   = 16'd111;
	localparam logic [15:0] TYPE_JOIN   = 16'd120;
	localparam logic [15:0] TYPE_LEFT   = 16'd121;

	// fixed payload sizes
	localparam logic [15:0] LEN_MOVE   = 16'd20;
	localparam logic [15:0] LEN_RESIZE = 16'd16;

	typedef enum logic [2:0] {
		K_MOVE     = 3'd0,
		K_RESIZE   = 3'd1,
		K_AMSG     = 3'd2,
		K_SMSG     = 3'd3,
		K_JOIN     = 3'd4,
		K_LEFT     = 3'd5,
		K_BADTYPE  = 3'd6,
		K_OVERSIZE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_ID   = 2'd1,
		PH_LEN  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t       frame_kind;
		logic [31:0] sender_id;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic [15:0] payload_length;
		logic        last;
	} result_t;

	// header size in bytes, type word included
	function automatic logic [3:0] hdr_bytes(input kind_t kind);
		logic [3:0] n;
		case (kind)
			K_AMSG:  n = 4'd8;
			K_SMSG:  n = 4'd4;
			K_JOIN:  n = 4'd7;
			K_LEFT:  n = 4'd6;
			default: n = 4'd2;
		endcase
		return n;
	endfunction

endpackage

/* src/tmd_if.sv */
// valid/ready channels of the typed message deframer
interface tmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tmd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_kind;
	logic [31:0] sender_id;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic [15:0] payload_length;
	logic        last;

	modport source (output valid, output frame_kind, output sender_id, output payload_byte,
		output byte_valid, output payload_length, output last, input ready);
	modport sink (input valid, input frame_kind, input sender_id, input payload_byte,
		input byte_valid, input payload_length, input last, output ready);
endinterface

/* src/tmd_in_reg.sv */
// input register stage of the deframer
module tmd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	tmd_in_if.sink     stream,
	input  logic       step,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import tmd_pkg::*;

	logic take;

	// room when empty or when the held beat moves on this cycle
	assign stream.ready = !valid_s1 || step;
	assign take = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= stream.in_byte;
		end
	end

endmodule

/* src/tmd_parser.sv */
// frame parser: header collection, length checks and payload counting
module tmd_parser #(
	parameter int MAX_FRAME = tmd_pkg::MAX_FRAME_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_s1,
	output logic             res_valid,
	output tmd_pkg::result_t res
);
	import tmd_pkg::*;

	localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(MAX_FRAME);

	phase_t      phase_q, phase_d;
	logic [7:0]  type_hi_q, type_hi_d;
	logic [1:0]  hcnt_q, hcnt_d;
	kind_t       kind_q, kind_d;
	logic [31:0] id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pcnt_q, pcnt_d;
	logic        halted_q, halted_d;

	logic               hdr_done;
	kind_t              fin_kind;
	logic [31:0]        fin_id;
	logic [15:0]        fin_len;
	logic [15:0]        pcnt_new;
	logic [31:0]        id_new;
	logic [15:0]        len_new;
	logic               len_end;
	logic [TOTAL_W-1:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			type_hi_q <= '0;
			hcnt_q    <= '0;
			kind_q    <= K_MOVE;
			id_q      <= '0;
			len_q     <= '0;
			pcnt_q    <= '0;
			halted_q  <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			type_hi_q <= type_hi_d;
			hcnt_q    <= hcnt_d;
			kind_q    <= kind_d;
			id_q      <= id_d;
			len_q     <= len_d;
			pcnt_q    <= pcnt_d;
			halted_q  <= halted_d;
		end
	end

	assign pcnt_new = pcnt_q + 16'd1;
	assign id_new   = {id_q[23:0], byte_s1};
	assign len_new  = {len_q[7:0], byte_s1};
	assign len_end  = (kind_q == K_JOIN) ? (hcnt_q == 2'd0) : (hcnt_q == 2'd1);

	always_comb begin
		phase_d   = phase_q;
		type_hi_d = type_hi_q;
		hcnt_d    = hcnt_q;
		kind_d    = kind_q;
		id_d      = id_q;
		len_d     = len_q;
		pcnt_d    = pcnt_q;
		halted_d  = halted_q;
		hdr_done  = 1'b0;
		fin_kind  = kind_q;
		fin_id    = id_q;
		fin_len   = len_q;
		res_valid = 1'b0;
		res       = '0;
		total     = '0;

		if (step && !halted_q) begin
			case (phase_q)
				PH_TYPE: begin
					if (hcnt_q == 2'd0) begin
						type_hi_d = byte_s1;
						hcnt_d    = 2'd1;
					end else begin
						hcnt_d = 2'd0;
						id_d   = '0;
						len_d  = '0;
						fin_id = '0;
						case ({type_hi_q, byte_s1})
							TYPE_MOVE: begin
								kind_d   = K_MOVE;
								len_d    = LEN_MOVE;
								fin_kind = K_MOVE;
								fin_len  = LEN_MOVE;
								hdr_done = 1'b1;
							end
							TYPE_RESIZE: begin
								kind_d   = K_RESIZE;
								len_d    = LEN_RESIZE;
								fin_kind = K_RESIZE;
								fin_len  = LEN_RESIZE;
								hdr_done = 1'b1;
							end
							TYPE_AMSG: begin
								kind_d  = K_AMSG;
								phase_d = PH_ID;
							end
							TYPE_SMSG: begin
								kind_d  = K_SMSG;
								phase_d = PH_LEN;
							end
							TYPE_JOIN: begin
								kind_d  = K_JOIN;
								phase_d = PH_ID;
							end
							TYPE_LEFT: begin
								kind_d  = K_LEFT;
								phase_d = PH_ID;
							end
							default: begin
								res_valid      = 1'b1;
								res.frame_kind = K_BADTYPE;
								res.last       = 1'b1;
								halted_d       = 1'b1;
							end
						endcase
					end
				end
				PH_ID: begin
					id_d = id_new;
					if (hcnt_q != 2'd3) begin
						hcnt_d = hcnt_q + 2'd1;
					end else begin
						hcnt_d = 2'd0;
						len_d  = '0;
						if (kind_q == K_LEFT) begin
							hdr_done = 1'b1;
							fin_id   = id_new;
							fin_len  = '0;
						end else begin
							phase_d = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					len_d = len_new;
					if (len_end) begin
						hcnt_d   = 2'd0;
						hdr_done = 1'b1;
						fin_len  = len_new;
					end else begin
						hcnt_d = hcnt_q + 2'd1;
					end
				end
				PH_DATA: begin
					pcnt_d             = pcnt_new;
					res_valid          = 1'b1;
					res.frame_kind     = kind_q;
					res.sender_id      = id_q;
					res.payload_byte   = byte_s1;
					res.byte_valid     = 1'b1;
					res.payload_length = len_q;
					res.last           = (pcnt_new >= len_q);
					if (pcnt_new >= len_q) begin
						phase_d = PH_TYPE;
						hcnt_d  = 2'd0;
						pcnt_d  = '0;
					end
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase

			// header complete: size check, then empty frame or payload
			if (hdr_done) begin
				total = TOTAL_W'(hdr_bytes(fin_kind)) + TOTAL_W'(fin_len);
				if (total > MaxTotal) begin
					res_valid          = 1'b1;
					res.frame_kind     = K_OVERSIZE;
					res.sender_id      = fin_id;
					res.payload_length = fin_len;
					res.last           = 1'b1;
					halted_d           = 1'b1;
				end else if (fin_len == 16'd0) begin
					res_valid      = 1'b1;
					res.frame_kind = fin_kind;
					res.sender_id  = fin_id;
					res.last       = 1'b1;
					phase_d        = PH_TYPE;
					hcnt_d         = 2'd0;
					pcnt_d         = '0;
				end else begin
					phase_d = PH_DATA;
					pcnt_d  = '0;
				end
			end
		end
	end

endmodule

/* src/tmd_out_reg.sv */
// result register driving the output channel
module tmd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tmd_pkg::result_t res,
	output logic             free,
	tmd_out_if.source        result
);
	import tmd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot can take a new result when empty or drained this cycle
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.frame_kind     = res_q.frame_kind;
	assign result.sender_id      = res_q.sender_id;
	assign result.payload_byte   = res_q.payload_byte;
	assign result.byte_valid     = res_q.byte_valid;
	assign result.payload_length = res_q.payload_length;
	assign result.last           = res_q.last;

endmodule

/* src/typed_message_deframer_top.sv */
// top level of the typed message deframer
//
// stream: one received byte per beat, valid/ready, field in_byte
// result: at most one beat per input byte, fields frame_kind, sender_id,
//   payload_byte, byte_valid, payload_length, last
// frames open with a big-endian 16-bit type word; header bytes give no
//   beat, each payload byte gives one, an empty frame gives one with last
// a taken byte is held in the input register, its beat in the result register
// throughput: one byte per cycle while the receiver drains, set by the single
//   parser step between the input register and the result register
// a result beat waiting on result.ready does not block the next byte as
//   long as the receiver drains it in the same cycle; a stalled receiver
//   holds the result register, then the input register, then stream.ready
// bad type or oversize frame: one error beat with last, then every byte
//   is taken and dropped until reset
// reset: arst_n clears parser state, both valid flags and the halt flag
// MAX_FRAME: largest frame in bytes, header included (64 to 65543)
module typed_message_deframer_top #(
	parameter int MAX_FRAME = tmd_pkg::MAX_FRAME_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tmd_in_if.sink    stream,
	tmd_out_if.source result
);
	import tmd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       step;
	logic       res_valid;
	result_t    res;

	// a held byte is parsed when the result slot has room
	assign step = valid_s1 && free;

	tmd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.step     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	tmd_parser #(
		.MAX_FRAME (MAX_FRAME)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// only bytes that yield a beat fill the result register
	tmd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res_valid),
		.res    (res),
		.free   (free),
		.result (result)
	);

endmodule

/* sim/typed_message_deframer_top_test.sv */
// stimulus, byte-level prediction and beat checking for the typed message deframer
`timescale 1ns / 1ps

module typed_message_deframer_top_test;
	import tmd_pkg::*;

	// largest frame the block is built for, header included
	localparam int FRAME_LIMIT = MAX_FRAME_DEF;
	// header sizes of the two frames whose length field can overflow the limit
	localparam int AMSG_HDR = 8;
	localparam int SMSG_HDR = 4;
	// random part stops once this many stream bytes have gone in
	localparam int RANDOM_BYTES = 60;
	// cycles left after the last expected beat, latency plus margin
	localparam int TAIL_CYCLES = 16;
	// mismatches printed in full, later ones only counted
	localparam int SHOW_LIMIT = 10;

	// how payload bytes are filled
	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	// receiver behavior over one stretch of cycles
	typedef enum {DRAIN_ALL, DRAIN_COIN, DRAIN_PATTERN, DRAIN_SLOW} drain_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	tmd_in_if  stream_if ();
	tmd_out_if result_if ();

	typed_message_deframer_top #(
		.MAX_FRAME(FRAME_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.result(result_if)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// parser copy kept by the testbench: one call per accepted stream beat
	// ------------------------------------------------------------------
	phase_t      ph;
	logic [15:0] type_acc;
	kind_t       kind_q;
	int unsigned hdr_cnt;         // bytes taken in the current header field
	int unsigned hdr_bytes_seen;  // header bytes of this frame, type word included
	logic [31:0] id_q;
	logic [15:0] len_q;
	logic [15:0] pay_cnt;
	bit          halted_q;

	// result beats still owed by the block, oldest first
	result_t due_beats [$];

	int unsigned bad_beats;   // mismatches plus unexpected beats
	int unsigned bytes_sent;
	int unsigned burst_left;

	function automatic void add_due_beat(kind_t k, logic [31:0] id, logic [7:0] d,
		logic v, logic [15:0] n, logic l);
		result_t r;
		r.frame_kind     = k;
		r.sender_id      = id;
		r.payload_byte   = d;
		r.byte_valid     = v;
		r.payload_length = n;
		r.last           = l;
		due_beats.push_back(r);
	endfunction

	function automatic void start_next_frame();
		ph             = PH_TYPE;
		hdr_cnt        = 0;
		hdr_bytes_seen = 0;
		pay_cnt        = '0;
	endfunction

	function automatic void clear_parser();
		start_next_frame();
		type_acc = '0;
		kind_q   = K_MOVE;
		id_q     = '0;
		len_q    = '0;
		halted_q = 1'b0;
	endfunction

	// whole header in: size check, then empty frame or payload
	function automatic void close_header();
		if (int'(hdr_bytes_seen) + int'(len_q) > FRAME_LIMIT) begin
			add_due_beat(K_OVERSIZE, id_q, 8'h00, 1'b0, len_q, 1'b1);
			halted_q = 1'b1;
		end else if (len_q == 16'd0) begin
			add_due_beat(kind_q, id_q, 8'h00, 1'b0, 16'd0, 1'b1);
			start_next_frame();
		end else begin
			ph      = PH_DATA;
			pay_cnt = '0;
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		if (halted_q)
			return;
		case (ph)
			PH_TYPE: begin
				type_acc = {type_acc[7:0], b};
				hdr_cnt++;
				hdr_bytes_seen++;
				if (hdr_cnt == 2) begin
					hdr_cnt = 0;
					id_q    = '0;
					len_q   = '0;
					case (type_acc)
						TYPE_MOVE: begin
							kind_q = K_MOVE;
							len_q  = LEN_MOVE;
							close_header();
						end
						TYPE_RESIZE: begin
							kind_q = K_RESIZE;
							len_q  = LEN_RESIZE;
							close_header();
						end
						TYPE_AMSG: begin
							kind_q = K_AMSG;
							ph     = PH_ID;
						end
						TYPE_SMSG: begin
							kind_q = K_SMSG;
							ph     = PH_LEN;
						end
						TYPE_JOIN: begin
							kind_q = K_JOIN;
							ph     = PH_ID;
						end
						TYPE_LEFT: begin
							kind_q = K_LEFT;
							ph     = PH_ID;
						end
						default: begin
							add_due_beat(K_BADTYPE, '0, 8'h00, 1'b0, 16'd0, 1'b1);
							halted_q = 1'b1;
						end
					endcase
				end
			end
			PH_ID: begin
				id_q = {id_q[23:0], b};
				hdr_cnt++;
				hdr_bytes_seen++;
				if (hdr_cnt == 4) begin
					hdr_cnt = 0;
					len_q   = '0;
					if (kind_q == K_LEFT)
						close_header();
					else
						ph = PH_LEN;
				end
			end
			PH_LEN: begin
				len_q = {len_q[7:0], b};
				hdr_cnt++;
				hdr_bytes_seen++;
				if (hdr_cnt == ((kind_q == K_JOIN) ? 1 : 2)) begin
					hdr_cnt = 0;
					close_header();
				end
			end
			default: begin
				pay_cnt++;
				add_due_beat(kind_q, id_q, b, 1'b1, len_q, pay_cnt >= len_q);
				if (pay_cnt >= len_q)
					start_next_frame();
			end
		endcase
	endfunction

	function automatic void log_failure(input string msg);
		bad_beats++;
		if (bad_beats <= SHOW_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// sender: bursts of random length, random gaps between them
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				stream_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		stream_if.valid   <= 1'b1;
		stream_if.in_byte <= b;
		// valid stays up until the beat is taken
		do
			@(posedge clk);
		while (!stream_if.ready);
		parse_byte(b);
		bytes_sent++;
	endtask

	// type word and header fields; n is the payload size the header announces
	task automatic send_header(input kind_t k, input logic [31:0] id, input logic [15:0] len,
		output int unsigned n);
		logic [15:0] word;
		case (k)
			K_MOVE:   word = TYPE_MOVE;
			K_RESIZE: word = TYPE_RESIZE;
			K_AMSG:   word = TYPE_AMSG;
			K_SMSG:   word = TYPE_SMSG;
			K_JOIN:   word = TYPE_JOIN;
			default:  word = TYPE_LEFT;
		endcase
		send_byte(word[15:8]);
		send_byte(word[7:0]);
		if (k == K_AMSG || k == K_JOIN || k == K_LEFT) begin
			for (int i = 3; i >= 0; i--)
				send_byte(id[8*i +: 8]);
		end
		case (k)
			K_MOVE:   n = 32'(LEN_MOVE);
			K_RESIZE: n = 32'(LEN_RESIZE);
			K_AMSG, K_SMSG: begin
				send_byte(len[15:8]);
				send_byte(len[7:0]);
				n = 32'(len);
			end
			K_JOIN: begin
				send_byte(len[7:0]);
				n = 32'(len[7:0]);
			end
			default:  n = 0;
		endcase
	endtask

	task automatic send_message(input kind_t k, input logic [31:0] id, input logic [15:0] len,
		input fill_t fill);
		int unsigned n;
		send_header(k, id, len, n);
		for (int unsigned i = 0; i < n; i++) begin
			case (fill)
				FILL_ZERO: send_byte(8'h00);
				FILL_ONES: send_byte(8'hFF);
				default:   send_byte(8'($urandom));
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// test steps
	// ------------------------------------------------------------------

	// fixed-size frames, payload at both extremes and random
	task automatic test_fixed_frames();
		send_message(K_MOVE, '0, '0, FILL_ZERO);
		send_message(K_MOVE, '0, '0, FILL_ONES);
		send_message(K_RESIZE, '0, '0, FILL_RANDOM);
		send_message(K_RESIZE, '0, '0, FILL_ONES);
	endtask

	// frames with id or length fields or both, empty payloads among them
	task automatic test_header_frames();
		send_message(K_AMSG, 32'h0000_0000, 16'd1, FILL_ZERO);
		send_message(K_AMSG, 32'hFFFF_FFFF, 16'd3, FILL_ONES);
		send_message(K_AMSG, 32'h8001_7FFE, 16'd0, FILL_RANDOM);
		send_message(K_SMSG, '0, 16'd0, FILL_RANDOM);
		send_message(K_SMSG, '0, 16'd1, FILL_ONES);
		send_message(K_SMSG, '0, 16'd9, FILL_RANDOM);
		send_message(K_JOIN, 32'h1234_5678, 16'd0, FILL_RANDOM);
		send_message(K_JOIN, 32'hFFFF_FFFF, 16'd5, FILL_RANDOM);
		send_message(K_LEFT, 32'h0000_0000, '0, FILL_RANDOM);
		send_message(K_LEFT, 32'hFFFF_FFFF, '0, FILL_RANDOM);
		// back-to-back empty frames
		send_message(K_LEFT, $urandom, '0, FILL_RANDOM);
		send_message(K_SMSG, '0, 16'd0, FILL_RANDOM);
	endtask

	// longest name the 8-bit length field can announce
	task automatic test_size_limit();
		send_message(K_JOIN, $urandom, 16'd255, FILL_RANDOM);
	endtask

	// well-formed frames of random kind and content, mostly short
	task automatic test_random_frames();
		int unsigned stop_at;
		int unsigned pick;
		kind_t       k;
		logic [15:0] len;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at) begin
			k    = kind_t'($urandom_range(0, 5));
			pick = $urandom_range(0, 9);
			if (pick < 2)
				len = 16'd0;
			else if (pick < 8)
				len = 16'($urandom_range(1, 12));
			else
				len = 16'($urandom_range(13, 64));
			send_message(k, $urandom, len, FILL_RANDOM);
		end
	endtask

	// one error per run, bad type or oversize; afterwards every byte is dropped
	task automatic test_halt();
		logic [15:0] bad_words [8] = '{16'h0000, 16'hFFFF, 16'd99, 16'd102,
			16'd109, 16'd112, 16'd122, 16'h0164};
		logic [15:0] word;
		logic [15:0] len;
		int unsigned n;
		int          min_len;
		kind_t       k;
		case ($urandom_range(0, 2))
			0: begin
				word = bad_words[$urandom_range(0, 7)];
				if ($urandom_range(0, 1) == 1)
					word = 16'($urandom);
				while (word == TYPE_MOVE || word == TYPE_RESIZE || word == TYPE_AMSG ||
					word == TYPE_SMSG || word == TYPE_JOIN || word == TYPE_LEFT)
					word = 16'($urandom);
				send_byte(word[15:8]);
				send_byte(word[7:0]);
			end
			default: begin
				k       = ($urandom_range(0, 1) == 0) ? K_AMSG : K_SMSG;
				min_len = FRAME_LIMIT - ((k == K_AMSG) ? AMSG_HDR : SMSG_HDR) + 1;
				case ($urandom_range(0, 3))
					0:       len = 16'(min_len);
					1:       len = 16'hFFFF;
					default: len = 16'($urandom_range(min_len, 65535));
				endcase
				send_header(k, $urandom, len, n);
			end
		endcase
		// noise after the error beat, none of it may come out
		repeat ($urandom_range(8, 24))
			send_byte(8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// result checker: each taken beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			got.frame_kind     = kind_t'(result_if.frame_kind);
			got.sender_id      = result_if.sender_id;
			got.payload_byte   = result_if.payload_byte;
			got.byte_valid     = result_if.byte_valid;
			got.payload_length = result_if.payload_length;
			got.last           = result_if.last;
			if (due_beats.size() == 0) begin
				log_failure($sformatf(
					"unexpected beat: kind %0d id %h byte %h valid %b len %0d last %b",
					got.frame_kind, got.sender_id, got.payload_byte, got.byte_valid,
					got.payload_length, got.last));
			end else begin
				want = due_beats.pop_front();
				if (got.frame_kind !== want.frame_kind || got.sender_id !== want.sender_id ||
					got.payload_byte !== want.payload_byte ||
					got.byte_valid !== want.byte_valid ||
					got.payload_length !== want.payload_length || got.last !== want.last) begin
					log_failure($sformatf({"mismatch: expected kind %0d id %h byte %h valid %b",
						" len %0d last %b, got kind %0d id %h byte %h valid %b len %0d last %b"},
						want.frame_kind, want.sender_id, want.payload_byte, want.byte_valid,
						want.payload_length, want.last, got.frame_kind, got.sender_id,
						got.payload_byte, got.byte_valid, got.payload_length, got.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stretches of free draining, coin flips, a rotating mask and
	// slow draining, so stalls land on every phase of a frame
	// ------------------------------------------------------------------
	initial begin
		drain_mode_t mode;
		int unsigned span;
		logic [7:0]  mask;
		result_if.ready = 1'b0;
		mode = DRAIN_ALL;
		span = 0;
		mask = 8'hFF;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = drain_mode_t'($urandom_range(0, 3));
				span = $urandom_range(16, 200);
				mask = 8'($urandom) | 8'h01;
			end
			span--;
			case (mode)
				DRAIN_ALL:  result_if.ready <= 1'b1;
				DRAIN_COIN: result_if.ready <= ($urandom_range(0, 9) < 7);
				DRAIN_PATTERN: begin
					result_if.ready <= mask[0];
					mask = {mask[0], mask[7:1]};
				end
				default:    result_if.ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		stream_if.valid   = 1'b0;
		stream_if.in_byte = 8'h00;
		arst_n            = 1'b0;
		bad_beats         = 0;
		bytes_sent        = 0;
		burst_left        = 0;
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_frames();
		test_header_frames();
		test_size_limit();
		test_random_frames();
		// the block stays halted after this until reset, so it runs last
		test_halt();

		stream_if.valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		// a stray beat after the last expected one would show up here
		repeat (TAIL_CYCLES) @(posedge clk);

		if (bad_beats == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog, many times the slowest legal run
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
